>>> rtl/core/hcr_pkg.sv
// ----------------------------------------------------------------------------
// hcr_pkg
// Shared widths, ramp tables and payload types for the heat color ramp.
// ----------------------------------------------------------------------------
package hcr_pkg;

    // Field widths
    localparam int VALUE_BITS   = 16;
    localparam int CHANNEL_BITS = 8;

    // Ratio value/max as a fraction with 16 fractional bits, one extra bit for 1.0
    localparam int FRAC_BITS = 16;
    localparam int QUO_BITS  = FRAC_BITS + 1;

    // Ramp geometry
    localparam int NSEG       = 5;
    localparam int SEG_BITS   = 3;
    localparam int SPAN_BITS  = 15;   // widest segment span is 19661
    localparam int DEN_BITS   = 18;   // ten times the widest span
    localparam int TENTH_BITS = 4;
    localparam int NCHAN      = 4;
    localparam int NUM_BITS   = DEN_BITS + CHANNEL_BITS;

    // Lane order inside the channel divider
    localparam int LANE_RED   = 0;
    localparam int LANE_GREEN = 1;
    localparam int LANE_BLUE  = 2;
    localparam int LANE_ALPHA = 3;

    // Breakpoints 0, 0.2, 0.4, 0.5, 0.7, 1.0 in 16-bit fraction units
    localparam logic [QUO_BITS-1:0] SEG_EDGE [NSEG+1] = '{
        17'd0, 17'd13107, 17'd26214, 17'd32768, 17'd45875, 17'd65536
    };

    // Width of each segment
    localparam logic [SPAN_BITS-1:0] SEG_SPAN [NSEG] = '{
        15'd13107, 15'd13107, 15'd6554, 15'd13107, 15'd19661
    };

    // End colors in tenths: red, green, blue, alpha
    localparam logic [TENTH_BITS-1:0] RAMP_TENTHS [NSEG+1][NCHAN] = '{
        '{4'd0,  4'd0,  4'd0,  4'd2},   // black
        '{4'd0,  4'd0,  4'd10, 4'd4},   // blue
        '{4'd0,  4'd10, 4'd10, 4'd6},   // cyan
        '{4'd0,  4'd10, 4'd0,  4'd7},   // green
        '{4'd10, 4'd10, 4'd0,  4'd8},   // yellow
        '{4'd10, 4'd0,  4'd0,  4'd9}    // red
    };

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic [VALUE_BITS-1:0] peak;
    } in_t;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] red;
        logic [CHANNEL_BITS-1:0] green;
        logic [CHANNEL_BITS-1:0] blue;
        logic [CHANNEL_BITS-1:0] alpha;
    } out_t;

endpackage

>>> rtl/core/hcr_div_cell.sv
// ----------------------------------------------------------------------------
// hcr_div_cell
// One restoring division step per cell: doubles each lane's partial
// remainder, subtracts the shared divisor when it fits and shifts the
// quotient bit in. Each cell is a pipeline register with its own handshake.
// ----------------------------------------------------------------------------
module hcr_div_cell #(
    parameter int W     = 17,
    parameter int QW    = 17,
    parameter int LANES = 1
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [LANES-1:0][W-1:0]      in_rem,
    input  logic [W-1:0]                 in_dvs,
    input  logic [LANES-1:0][QW-1:0]     in_quo,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [LANES-1:0][W-1:0]      out_rem,
    output logic [W-1:0]                 out_dvs,
    output logic [LANES-1:0][QW-1:0]     out_quo
);

    logic                     valid_reg;
    logic [LANES-1:0][W-1:0]  rem_reg, rem_next;
    logic [W-1:0]             dvs_reg;
    logic [LANES-1:0][QW-1:0] quo_reg, quo_next;
    logic [LANES-1:0][W:0]    dbl;
    logic [LANES-1:0]         take;

    // Stage takes a new request when empty or when its content moves on
    assign in_ready = !valid_reg || out_ready;

    // Compare and subtract, one quotient bit per lane
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            dbl[l]      = {in_rem[l], 1'b0};
            take[l]     = (dbl[l] >= {1'b0, in_dvs});
            rem_next[l] = take[l] ? W'(dbl[l] - {1'b0, in_dvs}) : dbl[l][W-1:0];
            quo_next[l] = {in_quo[l][QW-2:0], take[l]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            rem_reg <= rem_next;
            dvs_reg <= in_dvs;
            quo_reg <= quo_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_dvs   = dvs_reg;
    assign out_quo   = quo_reg;

endmodule

>>> rtl/core/hcr_seg_stage.sv
// ----------------------------------------------------------------------------
// hcr_seg_stage
// Picks the ramp segment for a ratio, registers segment and offset, and
// forms each channel's scaled numerator and the shared divisor for the
// channel divider.
// ----------------------------------------------------------------------------
module hcr_seg_stage (
    input  logic                                              aclk,
    input  logic                                              aresetn,
    input  logic                                              in_valid,
    output logic                                              in_ready,
    input  logic [hcr_pkg::QUO_BITS-1:0]                      in_quo,
    output logic                                              out_valid,
    input  logic                                              out_ready,
    output logic [hcr_pkg::NCHAN-1:0][hcr_pkg::NUM_BITS-1:0]  out_num,
    output logic [hcr_pkg::NUM_BITS-1:0]                      out_dvs
);

    localparam int LVL_BITS = hcr_pkg::SPAN_BITS + 6;
    localparam int CB       = hcr_pkg::CHANNEL_BITS;

    logic                           valid_reg;
    logic [hcr_pkg::SEG_BITS-1:0]   seg_reg, seg_next;
    logic [hcr_pkg::SPAN_BITS-1:0]  ofs_reg, ofs_next;
    logic [hcr_pkg::SPAN_BITS-1:0]  span;
    logic [hcr_pkg::DEN_BITS-1:0]   ten_span;
    logic signed [LVL_BITS-1:0]     span_s, ofs_s;
    logic signed [LVL_BITS-1:0]     c0_s [hcr_pkg::NCHAN];
    logic signed [LVL_BITS-1:0]     c1_s [hcr_pkg::NCHAN];
    logic signed [LVL_BITS-1:0]     lvl_s [hcr_pkg::NCHAN];
    logic [hcr_pkg::DEN_BITS-1:0]   base [hcr_pkg::NCHAN];

    assign in_ready = !valid_reg || out_ready;

    // Segment search; a full ratio lands at the end of the last segment
    always_comb begin
        seg_next = '0;
        for (int i = 1; i < hcr_pkg::NSEG; i++) begin
            if (in_quo >= hcr_pkg::SEG_EDGE[i]) begin
                seg_next = hcr_pkg::SEG_BITS'(i);
            end
        end
        priority if (in_quo[hcr_pkg::FRAC_BITS]) begin
            ofs_next = hcr_pkg::SEG_SPAN[hcr_pkg::NSEG-1];
        end else begin
            ofs_next = hcr_pkg::SPAN_BITS'(in_quo - hcr_pkg::SEG_EDGE[seg_next]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            seg_reg <= seg_next;
            ofs_reg <= ofs_next;
        end
    end

    // Interpolated level in tenths times span, then scaled by full channel
    always_comb begin
        span     = hcr_pkg::SEG_SPAN[seg_reg];
        ten_span = hcr_pkg::DEN_BITS'({span, 3'b000}) + hcr_pkg::DEN_BITS'({span, 1'b0});
        span_s   = LVL_BITS'(span);
        ofs_s    = LVL_BITS'(ofs_reg);
        for (int l = 0; l < hcr_pkg::NCHAN; l++) begin
            c0_s[l]    = LVL_BITS'(hcr_pkg::RAMP_TENTHS[seg_reg][l]);
            c1_s[l]    = LVL_BITS'(hcr_pkg::RAMP_TENTHS[hcr_pkg::SEG_BITS'(seg_reg + 1'b1)][l]);
            lvl_s[l]   = c0_s[l] * span_s + (c1_s[l] - c0_s[l]) * ofs_s;
            base[l]    = lvl_s[l][hcr_pkg::DEN_BITS-1:0];
            out_num[l] = {base[l], {CB{1'b0}}} - hcr_pkg::NUM_BITS'(base[l]);
        end
        out_dvs = {ten_span, {CB{1'b0}}};
    end

    assign out_valid = valid_reg;

endmodule

>>> rtl/core/heat_color_ramp.sv
// ----------------------------------------------------------------------------
// heat_color_ramp
// Maps a density count and its maximum to an RGBA heat color.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry a request {value, peak}; it is taken
//   at a rising edge with s_valid and s_ready high. m_valid/m_ready/m_data
//   return one color {red, green, blue, alpha} per request, in order.
//   A zero maximum gives black at alpha 0.2; a value at or above the
//   maximum gives red at alpha 0.9.
//   The pipeline has 17 ratio divider cells (one quotient bit each),
//   one segment stage and 8 channel divider cells (one channel bit each,
//   four lanes side by side). The last channel cell is the output register.
//   Throughput is one request per cycle while m_ready is high, set by the single-step cells.
//   Every cell has its own valid bit, so when the receiver stalls the
//   results back up one cell at a time and empty cells keep taking new
//   requests; s_ready falls only once the whole chain is full.
//   Reset (aresetn low, synchronous) empties all cells; nothing else is
//   held across requests.
// ----------------------------------------------------------------------------
module heat_color_ramp (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  hcr_pkg::in_t   s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output hcr_pkg::out_t  m_data
);

    localparam int QW     = hcr_pkg::QUO_BITS;
    localparam int QDIV_W = hcr_pkg::VALUE_BITS + 1;
    localparam int QSTEPS = hcr_pkg::QUO_BITS;
    localparam int CB     = hcr_pkg::CHANNEL_BITS;
    localparam int NW     = hcr_pkg::NUM_BITS;
    localparam int NCH    = hcr_pkg::NCHAN;

    // Ratio divider chain
    logic                      q_valid [QSTEPS+1];
    logic                      q_ready [QSTEPS+1];
    logic [0:0][QDIV_W-1:0]    q_rem   [QSTEPS+1];
    logic [QDIV_W-1:0]         q_dvs   [QSTEPS+1];
    logic [0:0][QW-1:0]        q_quo   [QSTEPS+1];

    // Channel divider chain
    logic                      c_valid [CB+1];
    logic                      c_ready [CB+1];
    logic [NCH-1:0][NW-1:0]    c_rem   [CB];
    logic [NW-1:0]             c_dvs   [CB];
    logic [NCH-1:0][CB-1:0]    c_quo   [CB+1];

    logic                      max_zero;
    logic                      val_sat;

    // Ratio setup: divide by twice the maximum over 17 steps so a full
    // ratio comes out as exactly 1.0; a zero maximum becomes a zero ratio
    assign max_zero = (s_data.peak == '0);
    assign val_sat  = (s_data.value >= s_data.peak);

    always_comb begin
        priority if (max_zero) begin
            q_rem[0][0] = '0;
            q_dvs[0]    = QDIV_W'(2);
        end else if (val_sat) begin
            q_rem[0][0] = QDIV_W'(s_data.peak);
            q_dvs[0]    = {s_data.peak, 1'b0};
        end else begin
            q_rem[0][0] = QDIV_W'(s_data.value);
            q_dvs[0]    = {s_data.peak, 1'b0};
        end
    end

    assign q_valid[0] = s_valid;
    assign s_ready    = q_ready[0];
    assign q_quo[0]   = '0;

    for (genvar i = 0; i < QSTEPS; i++) begin : g_qcell
        hcr_div_cell #(
            .W     (QDIV_W),
            .QW    (QW),
            .LANES (1)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (q_valid[i]),
            .in_ready  (q_ready[i]),
            .in_rem    (q_rem[i]),
            .in_dvs    (q_dvs[i]),
            .in_quo    (q_quo[i]),
            .out_valid (q_valid[i+1]),
            .out_ready (q_ready[i+1]),
            .out_rem   (q_rem[i+1]),
            .out_dvs   (q_dvs[i+1]),
            .out_quo   (q_quo[i+1])
        );
    end

    // Segment selection and channel numerators
    hcr_seg_stage u_seg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_valid[QSTEPS]),
        .in_ready  (q_ready[QSTEPS]),
        .in_quo    (q_quo[QSTEPS][0]),
        .out_valid (c_valid[0]),
        .out_ready (c_ready[0]),
        .out_num   (c_rem[0]),
        .out_dvs   (c_dvs[0])
    );

    assign c_quo[0] = '0;

    for (genvar i = 0; i < CB; i++) begin : g_ccell
        if (i < CB - 1) begin : g_mid
            hcr_div_cell #(
                .W     (NW),
                .QW    (CB),
                .LANES (NCH)
            ) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .in_valid  (c_valid[i]),
                .in_ready  (c_ready[i]),
                .in_rem    (c_rem[i]),
                .in_dvs    (c_dvs[i]),
                .in_quo    (c_quo[i]),
                .out_valid (c_valid[i+1]),
                .out_ready (c_ready[i+1]),
                .out_rem   (c_rem[i+1]),
                .out_dvs   (c_dvs[i+1]),
                .out_quo   (c_quo[i+1])
            );
        end else begin : g_last
            hcr_div_cell #(
                .W     (NW),
                .QW    (CB),
                .LANES (NCH)
            ) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .in_valid  (c_valid[i]),
                .in_ready  (c_ready[i]),
                .in_rem    (c_rem[i]),
                .in_dvs    (c_dvs[i]),
                .in_quo    (c_quo[i]),
                .out_valid (c_valid[i+1]),
                .out_ready (c_ready[i+1]),
                .out_rem   (),
                .out_dvs   (),
                .out_quo   (c_quo[i+1])
            );
        end
    end

    // Result channel straight from the last cell
    assign m_valid     = c_valid[CB];
    assign c_ready[CB] = m_ready;

    assign m_data.red   = c_quo[CB][hcr_pkg::LANE_RED];
    assign m_data.green = c_quo[CB][hcr_pkg::LANE_GREEN];
    assign m_data.blue  = c_quo[CB][hcr_pkg::LANE_BLUE];
    assign m_data.alpha = c_quo[CB][hcr_pkg::LANE_ALPHA];

endmodule
